/* rtl/core/fgps_pkg.sv */
// ----------------------------------------------------------------------------
// fgps_pkg
// shared constants, types and codes of the grid parent selector
// ----------------------------------------------------------------------------
`default_nettype none

package fgps_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int STORE      = MAX_ROWS * MAX_COLS;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int IDX_W      = $clog2(STORE);
    localparam int DIST_W     = 32;
    localparam int LVL_W      = 7;
    localparam int CFG_W      = 7;
    localparam int CFG_RESET  = 64;
    localparam int HOP_LIMIT  = 2 * (MAX_ROWS + MAX_COLS) + 8;
    localparam int HOP_W      = $clog2(HOP_LIMIT + 1);
    localparam int ADDR_W     = 3;
    localparam int OUT_DATA_W = 24;

    localparam logic [1:0] DIR_ROOT = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DIAG = 2'd2;
    localparam logic [1:0] DIR_LEFT = 2'd3;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [LVL_W-1:0]  lvl_t;

    typedef enum logic [1:0] {
        KIND_ROOT,
        KIND_ROW0,
        KIND_COL0,
        KIND_INNER
    } kind_t;

    typedef struct packed {
        dist_t              distance;
        kind_t              kind;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        idx_t               d;
        idx_t               a;
        idx_t               b;
        idx_t               c;
        logic               last;
    } item_t;

    typedef struct packed {
        logic  ok;
        idx_t  tgt;
        dist_t val;
    } link_t;

    typedef struct packed {
        idx_t par;
        lvl_t lvl;
    } pl_t;

    typedef struct packed {
        logic  ok;
        dist_t val;
    } max_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_PRE_RD,
        ST_PRE_CAP,
        ST_WK_RU,
        ST_WK_CU,
        ST_WK_RV,
        ST_WK_CV,
        ST_WK_STEP,
        ST_WR_AC,
        ST_WR_D,
        ST_WR_EDGE,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

/* rtl/core/frechet_grid_parent_selector_core.sv */
// the three ancestor walks of an interior cell share one read port on the cell
// stores, and the back end works on one cell at a time: a cell's result is loaded
// into the output register before the next cell is popped from the queue
// a two-deep request queue lets inputs arrive while a cell is being worked on
// reset: synchronous active-low, counters to (0,0), sizes to 64, stores kept
// ----------------------------------------------------------------------------
// frechet_grid_parent_selector_core
// streaming parent selector over a grid of point-pair distances
// ----------------------------------------------------------------------------
`default_nettype none

module frechet_grid_parent_selector_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fgps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [31:0]                 s_tdata,   // distance
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // parent_dir, cell_row, cell_col, cell_depth, zero pad
    output logic [fgps_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tlast    // last_cell
);
    import fgps_pkg::*;

    item_t      push_item, pop_item;
    logic       q_push, q_pop, q_full, q_empty;
    logic [1:0] o_dir;
    logic [5:0] o_row, o_col;
    logic [6:0] o_depth;

    assign pready = 1'b1;

    fgps_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_dist(s_tdata),
        .q_push(q_push), .q_item(push_item), .q_full(q_full)
    );

    fgps_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_item(push_item),
        .pop(q_pop), .pop_item(pop_item),
        .full(q_full), .empty(q_empty)
    );

    fgps_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_item(pop_item), .q_empty(q_empty), .q_pop(q_pop),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_dir(o_dir), .out_row(o_row), .out_col(o_col),
        .out_depth(o_depth), .out_last(m_tlast)
    );

    assign m_tdata = {3'b000, o_depth, o_col, o_row, o_dir};

endmodule

`default_nettype wire

/* rtl/core/fgps_ram.sv */
// ----------------------------------------------------------------------------
// fgps_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fgps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/fgps_queue.sv */
// ----------------------------------------------------------------------------
// fgps_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module fgps_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  fgps_pkg::item_t     push_item,
    input  wire logic           pop,
    output fgps_pkg::item_t     pop_item,
    output logic                full,
    output logic                empty
);
    import fgps_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'((push && !full) ? 1 : 0)
                                   - 2'((pop && !empty) ? 1 : 0);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/fgps_front.sv */
// ----------------------------------------------------------------------------
// fgps_front
// register port, grid position counters and cell classification
// ----------------------------------------------------------------------------
`default_nettype none

module fgps_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fgps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [31:0]                 in_dist,
    output logic                             q_push,
    output fgps_pkg::item_t                  q_item,
    input  wire logic                        q_full
);
    import fgps_pkg::*;

    logic [CFG_W-1:0] rows_cfg_reg;
    logic [CFG_W-1:0] cols_cfg_reg;
    logic [ROW_W-1:0] row_cnt_reg;
    logic [COL_W-1:0] col_cnt_reg;
    logic [ROW_W-1:0] row_cnt_next;
    logic [COL_W-1:0] col_cnt_next;

    logic [CFG_W-1:0] rows_eff;
    logic [CFG_W-1:0] cols_eff;
    logic             wrap;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    idx_t             d;
    idx_t             a;
    idx_t             cl;
    kind_t            kind;
    logic             cfg_wr;

    assign cfg_wr   = psel && penable && pwrite;
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb begin
        unique case (paddr[2])
            REG_ROWS: prdata = 32'(rows_cfg_reg);
            REG_COLS: prdata = 32'(cols_cfg_reg);
            default:  prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (rows_cfg_reg == '0) begin
            rows_eff = CFG_W'(1);
        end else if (rows_cfg_reg > CFG_W'(MAX_ROWS)) begin
            rows_eff = CFG_W'(MAX_ROWS);
        end else begin
            rows_eff = rows_cfg_reg;
        end
        if (cols_cfg_reg == '0) begin
            cols_eff = CFG_W'(1);
        end else if (cols_cfg_reg > CFG_W'(MAX_COLS)) begin
            cols_eff = CFG_W'(MAX_COLS);
        end else begin
            cols_eff = cols_cfg_reg;
        end

        wrap = (CFG_W'(row_cnt_reg) >= rows_eff) || (CFG_W'(col_cnt_reg) >= cols_eff);
        r    = wrap ? '0 : row_cnt_reg;
        c    = wrap ? '0 : col_cnt_reg;
        d    = IDX_W'(IDX_W'(r) * IDX_W'(cols_eff) + IDX_W'(c));
        a    = d - IDX_W'(cols_eff);
        cl   = d - IDX_W'(1);

        if (r == '0 && c == '0) begin
            kind = KIND_ROOT;
        end else if (r == '0) begin
            kind = KIND_ROW0;
        end else if (c == '0) begin
            kind = KIND_COL0;
        end else begin
            kind = KIND_INNER;
        end

        q_item.distance = in_dist;
        q_item.kind     = kind;
        q_item.row      = r;
        q_item.col      = c;
        q_item.d        = d;
        q_item.a        = (kind == KIND_ROW0) ? cl : a;
        q_item.b        = a - IDX_W'(1);
        q_item.c        = cl;
        q_item.last     = (CFG_W'(r) == rows_eff - CFG_W'(1))
                       && (CFG_W'(c) == cols_eff - CFG_W'(1));

        if (CFG_W'(c) + CFG_W'(1) < cols_eff) begin
            col_cnt_next = COL_W'(CFG_W'(c) + CFG_W'(1));
            row_cnt_next = r;
        end else begin
            col_cnt_next = '0;
            row_cnt_next = (CFG_W'(r) + CFG_W'(1) < rows_eff)
                         ? ROW_W'(CFG_W'(r) + CFG_W'(1)) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= CFG_W'(CFG_RESET);
            cols_cfg_reg <= CFG_W'(CFG_RESET);
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_ROWS: rows_cfg_reg <= pwdata[CFG_W-1:0];
                    REG_COLS: cols_cfg_reg <= pwdata[CFG_W-1:0];
                    default:  ;
                endcase
            end
            if (q_push) begin
                row_cnt_reg <= row_cnt_next;
                col_cnt_reg <= col_cnt_next;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/fgps_back.sv */
// ----------------------------------------------------------------------------
// fgps_back
// ancestor walks over the cell stores, parent choice and shortcut rewrite
// ----------------------------------------------------------------------------
`default_nettype none

module fgps_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  fgps_pkg::item_t        q_item,
    input  wire logic              q_empty,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             out_dir,
    output logic [5:0]             out_row,
    output logic [5:0]             out_col,
    output logic [6:0]             out_depth,
    output logic                   out_last
);
    import fgps_pkg::*;

    state_t state_reg, state_next;

    item_t  cur_reg;
    logic [1:0] pre_idx_reg;
    logic [1:0] widx_reg;
    pl_t    pre_pl_reg   [3];
    dist_t  pre_dist_reg [3];

    idx_t   u_reg, v_reg;
    pl_t    u_pl_reg, v_pl_reg;
    dist_t  u_dist_reg, v_dist_reg;
    link_t  u_link_reg, v_link_reg;
    max_t   am_reg, bm_reg;
    logic [HOP_W-1:0] hops_reg;
    max_t   res_a_reg [3];
    max_t   res_b_reg [3];
    idx_t   res_n_reg [3];

    logic [1:0] dir_reg;
    lvl_t   depth_reg;
    logic   out_valid_reg;

    idx_t   raddr;
    dist_t  dist_rd;
    pl_t    pl_rd;
    link_t  low_rd, high_rd;
    logic   dist_we, pl_we, low_we, high_we;
    idx_t   pl_wa, low_wa, high_wa;
    pl_t    pl_wd;
    link_t  low_wd, high_wd;

    logic   walk_done, load_out, walk_start;
    logic [1:0] widx_start;

    logic   ab_win, bc_win, ac_win, pa_ab, pc_bc;
    logic [1:0] dir;
    idx_t   par;
    lvl_t   par_lvl;
    dist_t  dd;
    logic   la_en, hc_en, ld_en, hd_en;
    link_t  la, hc, ld, hd;

    function automatic logic le_max(max_t x, max_t y);
        return !x.ok || (y.ok && x.val <= y.val);
    endfunction

    function automatic max_t upd_max(max_t m, dist_t x);
        max_t r;
        r = m;
        if (!m.ok || x > m.val) begin
            r.ok  = 1'b1;
            r.val = x;
        end
        return r;
    endfunction

    function automatic dist_t to_link(max_t m);
        return m.ok ? m.val : '0;
    endfunction

    function automatic dist_t max_dd(max_t m, dist_t x);
        return (m.ok && m.val > x) ? m.val : x;
    endfunction

    function automatic link_t mk(idx_t t, dist_t v);
        link_t l;
        l.ok  = 1'b1;
        l.tgt = t;
        l.val = v;
        return l;
    endfunction

    function automatic idx_t walk_u(item_t it, logic [1:0] w);
        return (w == 2'd1) ? it.b : it.a;
    endfunction

    function automatic idx_t walk_v(item_t it, logic [1:0] w);
        return (w == 2'd0) ? it.b : it.c;
    endfunction

    fgps_ram #(.WIDTH(DIST_W), .DEPTH(STORE)) u_dist_ram (
        .aclk(aclk), .we(dist_we), .waddr(cur_reg.d), .wdata(cur_reg.distance),
        .raddr(raddr), .rdata(dist_rd)
    );
    fgps_ram #(.WIDTH($bits(pl_t)), .DEPTH(STORE)) u_pl_ram (
        .aclk(aclk), .we(pl_we), .waddr(pl_wa), .wdata(pl_wd),
        .raddr(raddr), .rdata(pl_rd)
    );
    fgps_ram #(.WIDTH($bits(link_t)), .DEPTH(STORE)) u_low_ram (
        .aclk(aclk), .we(low_we), .waddr(low_wa), .wdata(low_wd),
        .raddr(raddr), .rdata(low_rd)
    );
    fgps_ram #(.WIDTH($bits(link_t)), .DEPTH(STORE)) u_high_ram (
        .aclk(aclk), .we(high_we), .waddr(high_wa), .wdata(high_wd),
        .raddr(raddr), .rdata(high_rd)
    );

    // parent choice and shortcut plan
    always_comb begin
        dd     = cur_reg.distance;
        ab_win = le_max(res_a_reg[0], res_b_reg[0]);
        bc_win = le_max(res_a_reg[1], res_b_reg[1]);
        ac_win = le_max(res_a_reg[2], res_b_reg[2]);
        pa_ab  = (pre_pl_reg[0].par == cur_reg.b);
        pc_bc  = (pre_pl_reg[2].par == cur_reg.b);

        if (ab_win && ac_win) begin
            dir = DIR_UP;   par = cur_reg.a; par_lvl = pre_pl_reg[0].lvl;
        end else if (!ab_win && bc_win) begin
            dir = DIR_DIAG; par = cur_reg.b; par_lvl = pre_pl_reg[1].lvl;
        end else begin
            dir = DIR_LEFT; par = cur_reg.c; par_lvl = pre_pl_reg[2].lvl;
        end

        la_en = 1'b0; hc_en = 1'b0; ld_en = 1'b0; hd_en = 1'b0;
        la = '0; hc = '0; ld = '0; hd = '0;

        case (dir)
            DIR_UP: begin
                if (pa_ab && pc_bc) begin
                    la_en = 1'b1; la = mk(cur_reg.b, pre_dist_reg[0]);
                    hc_en = 1'b1; hc = mk(cur_reg.b, pre_dist_reg[2]);
                    ld_en = 1'b1;
                    ld = mk(cur_reg.b, (pre_dist_reg[0] > dd) ? pre_dist_reg[0] : dd);
                end else if (pa_ab) begin
                    la_en = 1'b1; la = mk(res_n_reg[2], to_link(res_a_reg[2]));
                    ld_en = 1'b1; ld = mk(res_n_reg[2], max_dd(res_a_reg[2], dd));
                end else if (pc_bc) begin
                    hc_en = 1'b1; hc = mk(res_n_reg[2], to_link(res_b_reg[2]));
                    ld_en = 1'b1; ld = mk(res_n_reg[2], max_dd(res_a_reg[2], dd));
                end else begin
                    ld_en = 1'b1; ld = mk(res_n_reg[0], max_dd(res_a_reg[0], dd));
                end
            end
            DIR_DIAG: begin
                if (pa_ab && pc_bc) begin
                    la_en = 1'b1; la = mk(cur_reg.b, pre_dist_reg[0]);
                    hc_en = 1'b1; hc = mk(cur_reg.b, pre_dist_reg[2]);
                    hd_en = 1'b1; hd = mk(cur_reg.b, dd);
                    ld_en = 1'b1; ld = mk(cur_reg.b, dd);
                end else if (pa_ab) begin
                    la_en = 1'b1; la = mk(cur_reg.b, pre_dist_reg[0]);
                    hd_en = 1'b1; hd = mk(cur_reg.b, dd);
                    ld_en = 1'b1; ld = mk(res_n_reg[2], max_dd(res_a_reg[1], dd));
                end else if (pc_bc) begin
                    hc_en = 1'b1; hc = mk(cur_reg.b, pre_dist_reg[2]);
                    hd_en = 1'b1; hd = mk(res_n_reg[2], max_dd(res_b_reg[0], dd));
                    ld_en = 1'b1; ld = mk(cur_reg.b, dd);
                end else begin
                    hd_en = 1'b1; hd = mk(res_n_reg[0], max_dd(res_b_reg[0], dd));
                    ld_en = 1'b1; ld = mk(res_n_reg[1], max_dd(res_a_reg[1], dd));
                end
            end
            default: begin
                if (pa_ab && pc_bc) begin
                    la_en = 1'b1; la = mk(cur_reg.b, pre_dist_reg[0]);
                    hc_en = 1'b1; hc = mk(cur_reg.b, pre_dist_reg[2]);
                    hd_en = 1'b1;
                    hd = mk(cur_reg.b, (pre_dist_reg[2] > dd) ? pre_dist_reg[2] : dd);
                end else if (pa_ab) begin
                    la_en = 1'b1; la = mk(res_n_reg[2], to_link(res_a_reg[2]));
                    hd_en = 1'b1; hd = mk(res_n_reg[2], max_dd(res_b_reg[2], dd));
                end else if (pc_bc) begin
                    hc_en = 1'b1; hc = mk(res_n_reg[2], to_link(res_b_reg[2]));
                    hd_en = 1'b1; hd = mk(res_n_reg[2], max_dd(res_b_reg[2], dd));
                end else begin
                    hd_en = 1'b1; hd = mk(res_n_reg[1], max_dd(res_b_reg[1], dd));
                end
            end
        endcase
    end

    assign walk_done = (u_reg == v_reg) || (hops_reg == HOP_W'(HOP_LIMIT));
    assign load_out  = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);
    assign walk_start = ((state_reg == ST_PRE_CAP) && (pre_idx_reg == 2'd2))
                     || ((state_reg == ST_WK_STEP) && walk_done && (widx_reg != 2'd2));
    assign widx_start = (state_reg == ST_PRE_CAP) ? 2'd0 : widx_reg + 2'd1;

    // next state, read address and write ports
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        raddr      = u_reg;
        dist_we    = 1'b0;
        pl_we      = 1'b0;
        low_we     = 1'b0;
        high_we    = 1'b0;
        pl_wa      = cur_reg.d;
        low_wa     = cur_reg.d;
        high_wa    = cur_reg.d;
        pl_wd      = '0;
        low_wd     = '0;
        high_wd    = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                dist_we = 1'b1;
                low_we  = 1'b1;
                high_we = 1'b1;
                if (cur_reg.kind == KIND_ROOT) begin
                    pl_we      = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_PRE_RD;
                end
            end
            ST_PRE_RD: begin
                case (pre_idx_reg)
                    2'd0:    raddr = cur_reg.a;
                    2'd1:    raddr = cur_reg.b;
                    default: raddr = cur_reg.c;
                endcase
                state_next = ST_PRE_CAP;
            end
            ST_PRE_CAP: begin
                if (cur_reg.kind != KIND_INNER) begin
                    state_next = ST_WR_EDGE;
                end else if (pre_idx_reg == 2'd2) begin
                    state_next = ST_WK_RU;
                end else begin
                    state_next = ST_PRE_RD;
                end
            end
            ST_WK_RU: begin
                raddr      = u_reg;
                state_next = ST_WK_CU;
            end
            ST_WK_CU: begin
                state_next = ST_WK_RV;
            end
            ST_WK_RV: begin
                raddr      = v_reg;
                state_next = ST_WK_CV;
            end
            ST_WK_CV: begin
                state_next = ST_WK_STEP;
            end
            ST_WK_STEP: begin
                if (walk_done) begin
                    state_next = (widx_reg == 2'd2) ? ST_WR_AC : ST_WK_RU;
                end else if (v_pl_reg.lvl > u_pl_reg.lvl) begin
                    state_next = ST_WK_RV;
                end else begin
                    state_next = ST_WK_RU;
                end
            end
            ST_WR_AC: begin
                low_we     = la_en;
                low_wa     = cur_reg.a;
                low_wd     = la;
                high_we    = hc_en;
                high_wa    = cur_reg.c;
                high_wd    = hc;
                state_next = ST_WR_D;
            end
            ST_WR_D: begin
                pl_we      = 1'b1;
                pl_wd.par  = par;
                pl_wd.lvl  = par_lvl + LVL_W'(1);
                low_we     = ld_en;
                low_wd     = ld;
                high_we    = hd_en;
                high_wd    = hd;
                state_next = ST_FIN;
            end
            ST_WR_EDGE: begin
                pl_we      = 1'b1;
                pl_wd.par  = cur_reg.a;
                pl_wd.lvl  = pre_pl_reg[0].lvl + LVL_W'(1);
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg     <= q_item;
            pre_idx_reg <= 2'd0;
        end
        if (state_reg == ST_PRE_CAP) begin
            pre_pl_reg[pre_idx_reg]   <= pl_rd;
            pre_dist_reg[pre_idx_reg] <= dist_rd;
            pre_idx_reg               <= pre_idx_reg + 2'd1;
        end
        if (walk_start) begin
            widx_reg <= widx_start;
            u_reg    <= walk_u(cur_reg, widx_start);
            v_reg    <= walk_v(cur_reg, widx_start);
            am_reg   <= '0;
            bm_reg   <= '0;
            hops_reg <= '0;
        end
        if (state_reg == ST_WK_CU) begin
            u_pl_reg   <= pl_rd;
            u_dist_reg <= dist_rd;
            u_link_reg <= low_rd;
        end
        if (state_reg == ST_WK_CV) begin
            v_pl_reg   <= pl_rd;
            v_dist_reg <= dist_rd;
            v_link_reg <= high_rd;
        end
        if (state_reg == ST_WK_STEP) begin
            if (walk_done) begin
                res_a_reg[widx_reg] <= am_reg;
                res_b_reg[widx_reg] <= bm_reg;
                res_n_reg[widx_reg] <= u_reg;
            end else begin
                hops_reg <= hops_reg + HOP_W'(1);
                if (v_pl_reg.lvl > u_pl_reg.lvl) begin
                    if (v_link_reg.ok) begin
                        bm_reg <= upd_max(bm_reg, v_link_reg.val);
                        v_reg  <= v_link_reg.tgt;
                    end else begin
                        bm_reg <= upd_max(bm_reg, v_dist_reg);
                        v_reg  <= v_pl_reg.par;
                    end
                end else begin
                    if (u_link_reg.ok) begin
                        am_reg <= upd_max(am_reg, u_link_reg.val);
                        u_reg  <= u_link_reg.tgt;
                    end else begin
                        am_reg <= upd_max(am_reg, u_dist_reg);
                        u_reg  <= u_pl_reg.par;
                    end
                end
            end
        end
        if (state_reg == ST_INIT) begin
            dir_reg   <= DIR_ROOT;
            depth_reg <= '0;
        end
        if (state_reg == ST_WR_EDGE) begin
            dir_reg   <= (cur_reg.kind == KIND_ROW0) ? DIR_LEFT : DIR_UP;
            depth_reg <= pre_pl_reg[0].lvl + LVL_W'(1);
        end
        if (state_reg == ST_WR_D) begin
            dir_reg   <= dir;
            depth_reg <= par_lvl + LVL_W'(1);
        end
        if (load_out) begin
            out_dir   <= dir_reg;
            out_row   <= 6'(cur_reg.row);
            out_col   <= 6'(cur_reg.col);
            out_depth <= 7'(depth_reg);
            out_last  <= cur_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
